### hw/rtl/cbd_pkg.sv
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared widths, operation codes and status codes for the ring buffer deque.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 8;

    localparam int FUNC_W   = 3;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t OP_PUSH_FRONT = 3'd0;
    localparam func_t OP_PUSH_BACK  = 3'd1;
    localparam func_t OP_POP_FRONT  = 3'd2;
    localparam func_t OP_POP_BACK   = 3'd3;
    localparam func_t OP_READ       = 3'd4;
    localparam func_t OP_CLEAR      = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

### hw/rtl/circular_buffer_deque.sv
// ----------------------------------------------------------------------------
// circular_buffer_deque
// Fixed-capacity double-ended queue kept in a circular single-port-read store.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one operation word: func,
//   value and index. Push front/back, pop front/back, read at an offset from
//   the front, or clear. A push into a full deque or a pop from an empty one
//   is rejected and reports a status, with no change of state.
//   Every operation gives exactly one result word on the output channel
//   (out_valid / out_stall): status, front and back entries, the read entry,
//   the entry count and an empty flag.
//   An accepted operation, with the read issued at acceptance, is held in a
//   one-deep result stage that loads the output register, raising out_valid,
//   once that register is free. One operation is accepted per cycle while
//   in_stall is low: the store is read at most once per operation (new front
//   after a pop front, new back after a pop back, or the addressed entry),
//   and the front and back values are otherwise kept in registers.
//   When the receiver stalls, the output register holds its word; one more
//   operation may be taken into the result stage, after which in_stall rises.
//   Reset clears the pointers, the count and both valid flags; the store
//   contents are kept and need no clearing pass.
// ----------------------------------------------------------------------------
module circular_buffer_deque #(
    parameter int DEPTH      = cbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = cbd_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  cbd_pkg::func_t                 func,
    input  logic [DATA_WIDTH-1:0]          value,
    input  logic [$clog2(DEPTH)-1:0]       index,

    output logic                           out_valid,
    input  logic                           out_stall,
    output cbd_pkg::status_t               status,
    output logic [DATA_WIDTH-1:0]          front_value,
    output logic [DATA_WIDTH-1:0]          back_value,
    output logic [DATA_WIDTH-1:0]          read_value,
    output logic [$clog2(DEPTH+1)-1:0]     count,
    output logic                           is_empty
);
    import cbd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [AW:0]   WRAP_SUM  = (AW + 1)'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // architectural state
    logic [AW-1:0]         front_ptr_reg, front_ptr_next;
    logic [AW-1:0]         back_ptr_reg,  back_ptr_next;
    logic [CW-1:0]         cnt_reg,       cnt_next;

    // cached end values; a set select flag means the value sits in rd_data_reg
    logic [DATA_WIDTH-1:0] front_q_reg,   front_q_next;
    logic [DATA_WIDTH-1:0] back_q_reg,    back_q_next;
    logic                  fsel_reg,      fsel_next;
    logic                  bsel_reg,      bsel_next;
    logic                  rsel_reg,      rsel_next;
    logic [DATA_WIDTH-1:0] rd_data_reg;

    // result stage
    logic                  busy_reg;
    status_t               pend_status_reg, pend_status_next;

    // output register
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [DATA_WIDTH-1:0] front_value_reg;
    logic [DATA_WIDTH-1:0] back_value_reg;
    logic [DATA_WIDTH-1:0] read_value_reg;
    logic [CW-1:0]         count_reg;

    logic                  accept;
    logic                  load_out;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] eff_front;
    logic [DATA_WIDTH-1:0] eff_back;
    logic [AW-1:0]         fp_inc;
    logic [AW-1:0]         fp_dec;
    logic [AW-1:0]         bp_inc;
    logic [AW-1:0]         bp_dec;
    logic [AW:0]           idx_sum;
    logic [AW-1:0]         idx_slot;

    assign load_out = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign eff_front = fsel_reg ? rd_data_reg : front_q_reg;
    assign eff_back  = bsel_reg ? rd_data_reg : back_q_reg;

    assign fp_inc = (front_ptr_reg == LAST_SLOT) ? '0 : front_ptr_reg + 1'b1;
    assign fp_dec = (front_ptr_reg == '0) ? LAST_SLOT : front_ptr_reg - 1'b1;
    assign bp_inc = (back_ptr_reg == LAST_SLOT) ? '0 : back_ptr_reg + 1'b1;
    assign bp_dec = (back_ptr_reg == '0) ? LAST_SLOT : back_ptr_reg - 1'b1;

    // front + offset, wrapped once
    assign idx_sum  = {1'b0, front_ptr_reg} + {1'b0, index};
    assign idx_slot = (idx_sum >= WRAP_SUM) ? AW'(idx_sum - WRAP_SUM) : idx_sum[AW-1:0];

    always_comb
    begin
        front_ptr_next   = front_ptr_reg;
        back_ptr_next    = back_ptr_reg;
        cnt_next         = cnt_reg;
        front_q_next     = eff_front;
        back_q_next      = eff_back;
        fsel_next        = 1'b0;
        bsel_next        = 1'b0;
        rsel_next        = 1'b0;
        pend_status_next = ST_OK;
        rd_en            = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = '0;

        case (func)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (cnt_reg == FULL_CNT)
                begin
                    pend_status_next = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == '0)
                    begin
                        front_ptr_next = '0;
                        back_ptr_next  = '0;
                        wr_addr        = '0;
                        front_q_next   = value;
                        back_q_next    = value;
                    end
                    else if (func == OP_PUSH_FRONT)
                    begin
                        front_ptr_next = fp_dec;
                        wr_addr        = fp_dec;
                        front_q_next   = value;
                    end
                    else
                    begin
                        back_ptr_next = bp_inc;
                        wr_addr       = bp_inc;
                        back_q_next   = value;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (cnt_reg == '0)
                begin
                    pend_status_next = ST_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        front_ptr_next = '0;
                        back_ptr_next  = '0;
                    end
                    else if (func == OP_POP_FRONT)
                    begin
                        front_ptr_next = fp_inc;
                        rd_en          = 1'b1;
                        rd_addr        = fp_inc;
                        fsel_next      = 1'b1;
                    end
                    else
                    begin
                        back_ptr_next = bp_dec;
                        rd_en         = 1'b1;
                        rd_addr       = bp_dec;
                        bsel_next     = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (CW'(index) < cnt_reg)
                begin
                    rd_en     = 1'b1;
                    rd_addr   = idx_slot;
                    rsel_next = 1'b1;
                end
                else
                begin
                    pend_status_next = ST_RANGE;
                end
            end
            OP_CLEAR:
            begin
                front_ptr_next = '0;
                back_ptr_next  = '0;
                cnt_next       = '0;
            end
            default:
            begin
                pend_status_next = ST_OK;
            end
        endcase
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (accept && rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_ptr_reg <= '0;
            back_ptr_reg  <= '0;
            cnt_reg       <= '0;
            fsel_reg      <= 1'b0;
            bsel_reg      <= 1'b0;
            rsel_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                front_ptr_reg <= front_ptr_next;
                back_ptr_reg  <= back_ptr_next;
                cnt_reg       <= cnt_next;
                fsel_reg      <= fsel_next;
                bsel_reg      <= bsel_next;
                rsel_reg      <= rsel_next;
                busy_reg      <= 1'b1;
            end
            else if (load_out)
            begin
                busy_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_q_reg     <= front_q_next;
            back_q_reg      <= back_q_next;
            pend_status_reg <= pend_status_next;
        end
        if (load_out)
        begin
            status_reg      <= pend_status_reg;
            count_reg       <= cnt_reg;
            front_value_reg <= (cnt_reg == '0) ? '0 : eff_front;
            back_value_reg  <= (cnt_reg == '0) ? '0 : eff_back;
            read_value_reg  <= rsel_reg ? rd_data_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign front_value = front_value_reg;
    assign back_value  = back_value_reg;
    assign read_value  = read_value_reg;
    assign count       = count_reg;
    assign is_empty    = (count_reg == '0);

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ring buffer deque. A behavioral deque predicts
// status, front, back, read entry, count and empty flag for every accepted
// operation; results are matched in order against the output channel while
// both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    import cbd_pkg::*;

    localparam int DEPTH   = DEPTH_DEF;
    localparam int DW      = DATA_WIDTH_DEF;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LATENCY = 2;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD   = 150;

    // func codes the block treats as no-ops
    localparam func_t OP_SPARE_A = 3'd6;
    localparam func_t OP_SPARE_B = 3'd7;

    typedef logic [DW-1:0]    word_t;
    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct {
        status_t status;
        word_t   front;
        word_t   back;
        word_t   rd;
        cnt_t    cnt;
        logic    empty;
    } deque_result_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    func_t   func = OP_CLEAR;
    word_t   value = '0;
    ptr_t    index = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    status_t status;
    word_t   front_value;
    word_t   back_value;
    word_t   read_value;
    cnt_t    count;
    logic    is_empty;

    // behavioral deque state
    word_t deque_slot [DEPTH];
    ptr_t  head_ptr = '0;
    ptr_t  tail_ptr = '0;
    cnt_t  fill_count = '0;

    deque_result_t pending_results [$];
    int fail_count = 0;
    int send_idle_max = 0;
    int recv_idle_max = 0;
    int recv_hold_cycles = 0;
    int quiet_cycles = 0;

    circular_buffer_deque dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .value       (value),
        .index       (index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .front_value (front_value),
        .back_value  (back_value),
        .read_value  (read_value),
        .count       (count),
        .is_empty    (is_empty)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic deque_result_t apply_deque_op(func_t op, word_t word, ptr_t offset);
        deque_result_t r;
        ptr_t slot;
        r.status = ST_OK;
        r.rd     = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill_count == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    if (fill_count == 0)
                    begin
                        head_ptr = '0;
                        tail_ptr = '0;
                        deque_slot[0] = word;
                    end
                    else if (op == OP_PUSH_FRONT)
                    begin
                        head_ptr = head_ptr - 1'b1;
                        deque_slot[head_ptr] = word;
                    end
                    else
                    begin
                        tail_ptr = tail_ptr + 1'b1;
                        deque_slot[tail_ptr] = word;
                    end
                    fill_count = fill_count + 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (fill_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (fill_count == 1)
                    begin
                        head_ptr = '0;
                        tail_ptr = '0;
                    end
                    else if (op == OP_POP_FRONT)
                        head_ptr = head_ptr + 1'b1;
                    else
                        tail_ptr = tail_ptr - 1'b1;
                    fill_count = fill_count - 1'b1;
                end
            end
            OP_READ:
            begin
                if (offset < fill_count)
                begin
                    slot = head_ptr + offset;
                    r.rd = deque_slot[slot];
                end
                else
                    r.status = ST_RANGE;
            end
            OP_CLEAR:
            begin
                head_ptr   = '0;
                tail_ptr   = '0;
                fill_count = '0;
            end
            default: ;
        endcase
        r.front = (fill_count != 0) ? deque_slot[head_ptr] : '0;
        r.back  = (fill_count != 0) ? deque_slot[tail_ptr] : '0;
        r.cnt   = fill_count;
        r.empty = (fill_count == 0);
        return r;
    endfunction

    // drive one operation word and wait until the block takes it
    task automatic send_op(func_t op, word_t word, ptr_t offset);
        int gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        value    <= word;
        index    <= offset;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pending_results.push_back(apply_deque_op(op, word, offset));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic ptr_t pick_offset();
        if ($urandom_range(0, 1) == 1 && fill_count != 0)
            return ptr_t'($urandom_range(0, fill_count - 1));
        return ptr_t'($urandom_range(0, DEPTH - 1));
    endfunction

    task automatic send_random_op(int push_pct);
        int r;
        func_t op;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else if (r < push_pct + 30)
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        else if (r < 95)
            op = OP_READ;
        else if (r < 98)
            op = OP_CLEAR;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        send_op(op, word_t'($urandom), pick_offset());
    endtask

    task automatic test_directed_ops();
        send_op(OP_POP_FRONT, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_POP_BACK, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_READ, word_t'($urandom), '0);
        send_op(OP_SPARE_A, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_SPARE_B, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_CLEAR, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_PUSH_BACK, 8'h00, ptr_t'($urandom));
        send_op(OP_PUSH_FRONT, 8'hff, ptr_t'($urandom));
        send_op(OP_PUSH_BACK, 8'ha5, ptr_t'($urandom));
        send_op(OP_PUSH_FRONT, 8'h5a, ptr_t'($urandom));
        send_op(OP_READ, word_t'($urandom), 4'd0);
        send_op(OP_READ, word_t'($urandom), 4'd3);
        send_op(OP_READ, word_t'($urandom), 4'd4);
        send_op(OP_READ, word_t'($urandom), 4'd15);
        send_op(OP_POP_FRONT, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_POP_BACK, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_POP_FRONT, word_t'($urandom), ptr_t'($urandom));
        // last entry leaves, pointers go home
        send_op(OP_POP_BACK, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_POP_BACK, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_PUSH_FRONT, 8'h3c, ptr_t'($urandom));
        send_op(OP_PUSH_BACK, 8'hc3, ptr_t'($urandom));
        send_op(OP_CLEAR, word_t'($urandom), ptr_t'($urandom));
        send_op(OP_READ, word_t'($urandom), '0);
        send_op(OP_PUSH_BACK, 8'h81, ptr_t'($urandom));
    endtask

    // push to full and past it, read around, then drain or clear
    task automatic test_fill_and_drain(int rounds);
        int extra;
        for (int n = 0; n < rounds; n++)
        begin
            while (fill_count < DEPTH)
                send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                        word_t'($urandom), ptr_t'($urandom));
            extra = $urandom_range(1, 3);
            repeat (extra)
                send_op($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                        word_t'($urandom), ptr_t'($urandom));
            send_op(OP_READ, word_t'($urandom), ptr_t'(DEPTH - 1));
            repeat (3)
                send_op(OP_READ, word_t'($urandom), pick_offset());
            if (n % 3 == 2)
                send_op(OP_CLEAR, word_t'($urandom), ptr_t'($urandom));
            else
            begin
                while (fill_count != 0)
                begin
                    send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                            word_t'($urandom), ptr_t'($urandom));
                    if ($urandom_range(0, 7) == 0)
                        send_op(OP_READ, word_t'($urandom), pick_offset());
                end
                extra = $urandom_range(1, 2);
                repeat (extra)
                    send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK,
                            word_t'($urandom), ptr_t'($urandom));
            end
        end
    endtask

    task automatic test_random_ops(int n, int push_pct);
        repeat (n)
            send_random_op(push_pct);
    endtask

    // receiver goes quiet while words keep coming, so the block must stall
    task automatic test_backpressure();
        recv_hold_cycles = LONG_HOLD;
        repeat (60)
            send_random_op(55);
        drain_results();
    endtask

    task automatic check_field(string name, word_t exp_v, word_t act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        deque_result_t exp_r;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no operation outstanding");
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("status", word_t'(exp_r.status), word_t'(status));
                check_field("front_value", exp_r.front, front_value);
                check_field("back_value", exp_r.back, back_value);
                check_field("read_value", exp_r.rd, read_value);
                check_field("count", word_t'(exp_r.cnt), word_t'(count));
                check_field("is_empty", word_t'(exp_r.empty), word_t'(is_empty));
            end
        end
    end

    // result side: random stall before each word, or one long hold on request
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            if (recv_hold_cycles > 0)
            begin
                gap = recv_hold_cycles;
                recv_hold_cycles = 0;
            end
            else
                gap = $urandom_range(0, recv_idle_max);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (deque_slot[i])
            deque_slot[i] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_max = 14;
        recv_idle_max = 14;
        test_directed_ops();

        send_idle_max = 0;
        recv_idle_max = 0;
        test_fill_and_drain(3);
        send_idle_max = 14;
        recv_idle_max = 14;
        test_fill_and_drain(3);

        send_idle_max = 0;
        recv_idle_max = 14;
        test_random_ops(280, 45);
        send_idle_max = 14;
        recv_idle_max = 0;
        test_random_ops(280, 60);
        drain_results();

        send_idle_max = 0;
        recv_idle_max = 0;
        test_backpressure();

        send_idle_max = 14;
        recv_idle_max = 14;
        test_random_ops(180, 35);

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
